// File: rtl/sls_pkg.sv
// Shared types and constants for the spot light sampler.
// Used by every module under rtl; no dependencies.
package sls_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 48;
    localparam int QDepth   = 4;
    localparam int QAw      = 2;

    localparam logic [CfgIdxW-1:0] CfgLightPosition = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgLightAxis     = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgLightColour   = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgFullCos       = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgEdgeCos       = 3'd4;

    localparam logic [14:0] FullCosReset = 15'd16384;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
    } t_point_in;

    typedef struct packed {
        logic               lit;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [16:0]        dist_res;
        logic [33:0]        density;
        logic [15:0]        radiance_r;
        logic [15:0]        radiance_g;
        logic [15:0]        radiance_b;
    } t_sample_out;

    typedef struct packed {
        logic [47:0] light_position;
        logic [47:0] light_axis;
        logic [47:0] light_colour;
        logic [14:0] full_cos;
        logic [14:0] edge_cos;
    } t_cfg;

    // Classified item handed from front to back: difference vector lanes x, y, z
    typedef struct packed {
        logic [2:0][16:0] d;
        logic             zero;
    } t_q_entry;

endpackage

// File: rtl/spot_light_sample.sv
// Channel  Dir  Handshake              Payload
// point    in   i_valid / o_stall      i_point  (t_point_in)
// sample   out  o_valid / i_stall      o_sample (t_sample_out)
// config   in   i_cfg_we               i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the output is not stalled; each item passes
// from acceptance to output through the 17-stage square root and the two
// 16-stage restoring dividers. Reset is synchronous, active low, and clears
// all valid state and loads the register defaults. A stall at the output
// freezes the back pipeline; the 4-entry queue and front register absorb
// incoming items until o_stall rises.
module spot_light_sample import sls_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  t_point_in           i_point,
    output logic                o_valid,
    input  logic                i_stall,
    output t_sample_out         o_sample,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_not_empty;
    t_q_entry q_wdata;
    t_q_entry q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_position <= '0;
            r_cfg.light_axis     <= '0;
            r_cfg.light_colour   <= '0;
            r_cfg.full_cos       <= FullCosReset;
            r_cfg.edge_cos       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgLightPosition: r_cfg.light_position <= i_cfg_data;
                CfgLightAxis:     r_cfg.light_axis     <= i_cfg_data;
                CfgLightColour:   r_cfg.light_colour   <= i_cfg_data;
                CfgFullCos:       r_cfg.full_cos       <= i_cfg_data[14:0];
                CfgEdgeCos:       r_cfg.edge_cos       <= i_cfg_data[14:0];
                default:          r_cfg                <= r_cfg;
            endcase
        end
    end

    sls_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_point  (i_point),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (q_wdata)
    );

    sls_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_wdata     (q_wdata),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_rdata     (q_rdata),
        .o_not_empty (q_not_empty)
    );

    sls_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_not_empty (q_not_empty),
        .i_q_data      (q_rdata),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample      (o_sample)
    );

endmodule

// File: rtl/sls_front.sv
// Front stage: accepts shading points, forms light - point and flags a zero vector.
// Depends on sls_pkg.
module sls_front import sls_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_point_in i_point,
    input  logic      i_q_full,
    output logic      o_push,
    output t_q_entry  o_entry
);

    logic     r_valid;
    t_q_entry r_entry;
    t_q_entry n_entry;
    logic     en;

    assign en      = !r_valid || !i_q_full;
    assign o_stall = !en;
    assign o_push  = r_valid && !i_q_full;
    assign o_entry = r_entry;

    always_comb begin
        n_entry.d[0] = {i_cfg.light_position[15], i_cfg.light_position[15:0]}
                     - {i_point.point_x[15], i_point.point_x};
        n_entry.d[1] = {i_cfg.light_position[31], i_cfg.light_position[31:16]}
                     - {i_point.point_y[15], i_point.point_y};
        n_entry.d[2] = {i_cfg.light_position[47], i_cfg.light_position[47:32]}
                     - {i_point.point_z[15], i_point.point_z};
        n_entry.zero = (n_entry.d[0] == '0) && (n_entry.d[1] == '0) && (n_entry.d[2] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_entry <= n_entry;
        end
    end

endmodule

// File: rtl/sls_queue.sv
// Short queue between front and back so each side stalls on its own.
// Depends on sls_pkg.
module sls_queue import sls_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_wdata,
    output logic     o_full,
    input  logic     i_pop,
    output t_q_entry o_rdata,
    output logic     o_not_empty
);

    t_q_entry         r_mem [QDepth];
    logic [QAw-1:0]   r_wp;
    logic [QAw-1:0]   r_rp;
    logic [QAw:0]     r_count;

    assign o_full      = (r_count == (QAw+1)'(QDepth));
    assign o_not_empty = (r_count != '0);
    assign o_rdata     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAw+1)'(QDepth))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != (QAw+1)'(QDepth)) || i_pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

endmodule

// File: rtl/sls_back.sv
// Back pipeline: squared distance, bit-per-stage square root, direction and
// falloff dividers, cone test and the output register. Depends on sls_pkg.
module sls_back import sls_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_not_empty,
    input  t_q_entry    i_q_data,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output t_sample_out o_sample
);

    typedef struct packed {
        logic             v;
        logic             zero;
        logic [2:0][16:0] d;
        logic [2:0][31:0] p;
    } t_a_st;

    typedef struct packed {
        logic             v;
        logic             zero;
        logic [2:0][16:0] d;
        logic [33:0]      sq;
        logic [16:0]      root;
        logic [19:0]      rem;
    } t_sq_st;

    typedef struct packed {
        logic             v;
        logic             zero;
        logic [33:0]      sq;
        logic [16:0]      dlen;
        logic [2:0]       neg;
        logic [2:0][31:0] num;
        logic [17:0]      div;
        logic [2:0][17:0] rem;
        logic [2:0][15:0] q;
    } t_dv_st;

    typedef struct packed {
        logic             v;
        logic             zero;
        logic [33:0]      sq;
        logic [16:0]      dlen;
        logic [2:0][15:0] dir;
    } t_dir_st;

    typedef struct packed {
        logic             v;
        logic             zero;
        logic [33:0]      sq;
        logic [16:0]      dlen;
        logic [2:0][15:0] dir;
        logic [2:0][31:0] prod;
    } t_mp_st;

    typedef struct packed {
        logic             v;
        logic             zero;
        logic [33:0]      sq;
        logic [16:0]      dlen;
        logic [2:0][15:0] dir;
        logic [19:0]      cosq;
    } t_cs_st;

    typedef struct packed {
        logic             v;
        logic             lit;
        logic             full;
        logic [33:0]      sq;
        logic [16:0]      dlen;
        logic [2:0][15:0] dir;
        logic [14:0]      num;
        logic [14:0]      den;
    } t_cl_st;

    typedef struct packed {
        logic             v;
        logic             lit;
        logic             full;
        logic [33:0]      sq;
        logic [16:0]      dlen;
        logic [2:0][15:0] dir;
        logic [14:0]      den;
        logic [2:0][30:0] prod;
        logic [2:0][14:0] rem;
        logic [2:0][15:0] q;
    } t_fd_st;

    logic        en;
    t_a_st       r_a;
    t_sq_st      r_s [18];
    t_dv_st      r_d [17];
    t_dir_st     r_dr;
    t_mp_st      r_mp;
    t_cs_st      r_cs;
    t_cl_st      r_cl;
    t_fd_st      r_f [17];
    logic        r_o_valid;
    t_sample_out r_out;

    // whole pipeline advances together whenever the output slot can take an item
    assign en       = !r_o_valid || !i_stall;
    assign o_pop    = en && i_q_not_empty;
    assign o_valid  = r_o_valid;
    assign o_sample = r_out;

    // ---------------- squares and sum
    t_a_st  n_a;
    t_sq_st n_s0;
    logic signed [33:0] sqr [3];

    always_comb begin
        n_a.v    = o_pop;
        n_a.zero = i_q_data.zero;
        n_a.d    = i_q_data.d;
        for (int k = 0; k < 3; k++) begin
            sqr[k]    = $signed(i_q_data.d[k]) * $signed(i_q_data.d[k]);
            n_a.p[k]  = sqr[k][31:0];
        end
        n_s0.v    = r_a.v;
        n_s0.zero = r_a.zero;
        n_s0.d    = r_a.d;
        n_s0.sq   = {2'b00, r_a.p[0]} + {2'b00, r_a.p[1]} + {2'b00, r_a.p[2]};
        n_s0.root = '0;
        n_s0.rem  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a    <= '0;
            r_s[0] <= '0;
        end else if (en) begin
            r_a    <= n_a;
            r_s[0] <= n_s0;
        end
    end

    // ---------------- square root, one result bit per stage
    logic [19:0] sq_trial [17];
    logic [19:0] sq_test  [17];

    for (genvar k = 0; k < 17; k++) begin : g_sqrt
        localparam int Bi = 16 - k;
        t_sq_st n_s;

        assign sq_trial[k] = {r_s[k].rem[17:0], r_s[k].sq[2*Bi+1 -: 2]};
        assign sq_test[k]  = {1'b0, r_s[k].root, 2'b01};

        always_comb begin
            n_s = r_s[k];
            if (sq_trial[k] >= sq_test[k]) begin
                n_s.rem  = sq_trial[k] - sq_test[k];
                n_s.root = {r_s[k].root[15:0], 1'b1};
            end else begin
                n_s.rem  = sq_trial[k];
                n_s.root = {r_s[k].root[15:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s[k+1] <= '0;
            end else if (en) begin
                r_s[k+1] <= n_s;
            end
        end
    end

    // ---------------- round distance, set up direction dividers
    t_dv_st      n_d0;
    logic [16:0] mag [3];

    always_comb begin
        n_d0.v    = r_s[17].v;
        n_d0.zero = r_s[17].zero;
        n_d0.sq   = r_s[17].sq;
        // round up when the remainder passes the root
        n_d0.dlen = r_s[17].root + 17'(r_s[17].rem > {3'b000, r_s[17].root});
        n_d0.div  = {n_d0.dlen, 1'b0};
        for (int k = 0; k < 3; k++) begin
            n_d0.neg[k] = r_s[17].d[k][16];
            mag[k]      = r_s[17].d[k][16] ? 17'(-r_s[17].d[k]) : r_s[17].d[k];
            n_d0.num[k] = {mag[k], 15'b0} + {15'b0, n_d0.dlen};
            n_d0.rem[k] = {2'b00, n_d0.num[k][31:16]};
            n_d0.q[k]   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d[0] <= '0;
        end else if (en) begin
            r_d[0] <= n_d0;
        end
    end

    logic [18:0] dv_t [16][3];

    for (genvar j = 0; j < 16; j++) begin : g_dirdiv
        localparam int Bi = 15 - j;
        t_dv_st n_dv;

        for (genvar k = 0; k < 3; k++) begin : g_lane
            assign dv_t[j][k] = {r_d[j].rem[k], r_d[j].num[k][Bi]};
        end

        always_comb begin
            n_dv = r_d[j];
            for (int k = 0; k < 3; k++) begin
                if (dv_t[j][k] >= {1'b0, r_d[j].div}) begin
                    n_dv.rem[k] = 18'(dv_t[j][k] - {1'b0, r_d[j].div});
                    n_dv.q[k]   = {r_d[j].q[k][14:0], 1'b1};
                end else begin
                    n_dv.rem[k] = dv_t[j][k][17:0];
                    n_dv.q[k]   = {r_d[j].q[k][14:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d[j+1] <= '0;
            end else if (en) begin
                r_d[j+1] <= n_dv;
            end
        end
    end

    // ---------------- saturate and sign the direction
    t_dir_st     n_dr;
    logic [15:0] qs [3];

    always_comb begin
        n_dr.v    = r_d[16].v;
        n_dr.zero = r_d[16].zero;
        n_dr.sq   = r_d[16].sq;
        n_dr.dlen = r_d[16].dlen;
        for (int k = 0; k < 3; k++) begin
            qs[k]       = (r_d[16].q[k] > 16'd16384) ? 16'd16384 : r_d[16].q[k];
            n_dr.dir[k] = r_d[16].neg[k] ? 16'(-qs[k]) : qs[k];
        end
    end

    // ---------------- dot product with the axis
    t_mp_st n_mp;
    t_cs_st n_cs;
    logic signed [33:0] dot;
    logic signed [35:0] cos_full;

    always_comb begin
        n_mp.v    = r_dr.v;
        n_mp.zero = r_dr.zero;
        n_mp.sq   = r_dr.sq;
        n_mp.dlen = r_dr.dlen;
        n_mp.dir  = r_dr.dir;
        for (int k = 0; k < 3; k++) begin
            n_mp.prod[k] = $signed(r_dr.dir[k]) * $signed(i_cfg.light_axis[16*k +: 16]);
        end

        dot = 34'($signed(r_mp.prod[0])) + 34'($signed(r_mp.prod[1]))
            + 34'($signed(r_mp.prod[2]));
        // negate, round half up, floor shift down to Q1.14
        cos_full  = 36'sd8192 - 36'(dot);
        n_cs.v    = r_mp.v;
        n_cs.zero = r_mp.zero;
        n_cs.sq   = r_mp.sq;
        n_cs.dlen = r_mp.dlen;
        n_cs.dir  = r_mp.dir;
        n_cs.cosq = cos_full[33:14];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dr <= '0;
            r_mp <= '0;
            r_cs <= '0;
        end else if (en) begin
            r_dr <= n_dr;
            r_mp <= n_mp;
            r_cs <= n_cs;
        end
    end

    // ---------------- cone test
    t_cl_st n_cl;
    logic   c_full;
    logic   c_band;
    logic signed [20:0] c_diff;

    always_comb begin
        c_full = $signed({r_cs.cosq[19], r_cs.cosq}) > $signed({6'b0, i_cfg.full_cos});
        c_band = !c_full
              && ($signed({r_cs.cosq[19], r_cs.cosq}) > $signed({6'b0, i_cfg.edge_cos}));
        c_diff = $signed({r_cs.cosq[19], r_cs.cosq}) - $signed({6'b0, i_cfg.edge_cos});
        n_cl.v    = r_cs.v;
        n_cl.lit  = !r_cs.zero && (c_full || c_band);
        n_cl.full = c_full;
        n_cl.sq   = r_cs.sq;
        n_cl.dlen = r_cs.dlen;
        n_cl.dir  = r_cs.dir;
        n_cl.num  = c_band ? c_diff[14:0] : 15'd0;
        // keep the divisor nonzero when the band is not used
        n_cl.den  = c_band ? 15'(i_cfg.full_cos - i_cfg.edge_cos) : 15'd1;
    end

    t_fd_st      n_f0;
    logic [30:0] fp [3];

    always_comb begin
        n_f0.v    = r_cl.v;
        n_f0.lit  = r_cl.lit;
        n_f0.full = r_cl.full;
        n_f0.sq   = r_cl.sq;
        n_f0.dlen = r_cl.dlen;
        n_f0.dir  = r_cl.dir;
        n_f0.den  = r_cl.den;
        for (int k = 0; k < 3; k++) begin
            fp[k]        = i_cfg.light_colour[16*k +: 16] * r_cl.num;
            n_f0.prod[k] = fp[k];
            n_f0.rem[k]  = fp[k][30:16];
            n_f0.q[k]    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cl   <= '0;
            r_f[0] <= '0;
        end else if (en) begin
            r_cl   <= n_cl;
            r_f[0] <= n_f0;
        end
    end

    // ---------------- falloff divider
    logic [15:0] fd_t [16][3];

    for (genvar j = 0; j < 16; j++) begin : g_falldiv
        localparam int Bi = 15 - j;
        t_fd_st n_fd;

        for (genvar k = 0; k < 3; k++) begin : g_lane
            assign fd_t[j][k] = {r_f[j].rem[k], r_f[j].prod[k][Bi]};
        end

        always_comb begin
            n_fd = r_f[j];
            for (int k = 0; k < 3; k++) begin
                if (fd_t[j][k] >= {1'b0, r_f[j].den}) begin
                    n_fd.rem[k] = 15'(fd_t[j][k] - {1'b0, r_f[j].den});
                    n_fd.q[k]   = {r_f[j].q[k][14:0], 1'b1};
                end else begin
                    n_fd.rem[k] = fd_t[j][k][14:0];
                    n_fd.q[k]   = {r_f[j].q[k][14:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_f[j+1] <= '0;
            end else if (en) begin
                r_f[j+1] <= n_fd;
            end
        end
    end

    // ---------------- output register
    t_sample_out n_out;
    logic [2:0][15:0] rad;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rad[k] = r_f[16].full ? i_cfg.light_colour[16*k +: 16] : r_f[16].q[k];
        end
        n_out = '0;
        if (r_f[16].lit) begin
            n_out.lit        = 1'b1;
            n_out.dir_x      = r_f[16].dir[0];
            n_out.dir_y      = r_f[16].dir[1];
            n_out.dir_z      = r_f[16].dir[2];
            n_out.dist_res   = r_f[16].dlen;
            n_out.density    = r_f[16].sq;
            n_out.radiance_r = rad[0];
            n_out.radiance_g = rad[1];
            n_out.radiance_b = rad[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_f[16].v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule

// File: tb/sls_checker.sv
// Checker for the spot light sampler: watches the point and sample channels,
// predicts each sample from its own copy of the registers and compares.
// Depends on sls_pkg.
`timescale 1ns / 1ps

module sls_checker import sls_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_stall_in,
    input  t_point_in           i_point,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  t_sample_out         i_sample,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    t_cfg        light_regs;
    t_sample_out sample_q[$];
    int          fail_total = 0;

    function automatic logic signed [63:0] lane16(logic [47:0] packed_v, int k);
        logic signed [15:0] v;
        v = packed_v[16*k +: 16];
        return 64'(v);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 34;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_sample_out shade_point(t_point_in p, t_cfg c);
        t_sample_out     s;
        longint          d[3];
        longint          dir[3];
        longint          dot;
        longint          cq;
        longint          x;
        longint unsigned sq;
        longint unsigned dlen;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned num;
        longint unsigned den;
        logic [47:0]     rad;
        logic [15:0]     pts[3];
        s = '0;
        sq = 0;
        dot = 0;
        pts[0] = p.point_x;
        pts[1] = p.point_y;
        pts[2] = p.point_z;
        for (int k = 0; k < 3; k++) begin
            d[k] = lane16(c.light_position, k) - longint'($signed(pts[k]));
            sq += longint'(d[k] * d[k]);
        end
        if (sq == 0) return s;
        dlen = isqrt(sq);
        if (sq - dlen * dlen > dlen) dlen += 1;
        for (int k = 0; k < 3; k++) begin
            mag = d[k] < 0 ? -d[k] : d[k];
            q = (mag * 32768 + dlen) / (2 * dlen);
            if (q > 16384) q = 16384;
            dir[k] = d[k] < 0 ? -longint'(q) : longint'(q);
            dot += dir[k] * lane16(c.light_axis, k);
        end
        x = -dot + 8192;
        cq = x >= 0 ? x / 16384 : -((-x + 16383) / 16384);
        if (cq > longint'(c.full_cos)) begin
            rad = c.light_colour;
        end else if (cq > longint'(c.edge_cos)) begin
            num = cq - longint'(c.edge_cos);
            den = longint'(c.full_cos) - longint'(c.edge_cos);
            for (int k = 0; k < 3; k++)
                rad[16*k +: 16] = 16'(longint'(c.light_colour[16*k +: 16]) * num / den);
        end else begin
            return s;
        end
        s.lit        = 1'b1;
        s.dir_x      = 16'(dir[0]);
        s.dir_y      = 16'(dir[1]);
        s.dir_z      = 16'(dir[2]);
        s.dist_res   = 17'(dlen);
        s.density    = 34'(sq);
        s.radiance_r = rad[15:0];
        s.radiance_g = rad[31:16];
        s.radiance_b = rad[47:32];
        return s;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_total++;
        end
    endtask

    assign o_pending    = sample_q.size();
    assign o_fail_count = fail_total;

    always @(posedge i_clk) begin
        t_sample_out e;
        if (!i_rst_n) begin
            light_regs <= '{48'd0, 48'd0, 48'd0, FullCosReset, 15'd0};
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgLightPosition: light_regs.light_position <= i_cfg_data;
                    CfgLightAxis:     light_regs.light_axis     <= i_cfg_data;
                    CfgLightColour:   light_regs.light_colour   <= i_cfg_data;
                    CfgFullCos:       light_regs.full_cos       <= i_cfg_data[14:0];
                    CfgEdgeCos:       light_regs.edge_cos       <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in)
                sample_q.push_back(shade_point(i_point, light_regs));
            if (i_out_valid && !i_out_stall) begin
                if (sample_q.size() == 0) begin
                    $error("sample with no item outstanding");
                    fail_total++;
                end else begin
                    e = sample_q.pop_front();
                    check_field("lit", e.lit, i_sample.lit);
                    check_field("dir_x", e.dir_x, i_sample.dir_x);
                    check_field("dir_y", e.dir_y, i_sample.dir_y);
                    check_field("dir_z", e.dir_z, i_sample.dir_z);
                    check_field("dist_res", e.dist_res, i_sample.dist_res);
                    check_field("density", e.density, i_sample.density);
                    check_field("radiance_r", e.radiance_r, i_sample.radiance_r);
                    check_field("radiance_g", e.radiance_g, i_sample.radiance_g);
                    check_field("radiance_b", e.radiance_b, i_sample.radiance_b);
                end
            end
        end
    end

endmodule

// File: tb/tb_top.sv
// Testbench top for the spot light sampler: drives points, configuration
// and output stalls, and gives the verdict. Depends on sls_pkg, spot_light_sample and sls_checker.
`timescale 1ns / 1ps

module tb_top;
    import sls_pkg::*;

    localparam int IdleLimit = 20000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    t_point_in           i_point = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    t_sample_out         o_sample;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = CfgLightPosition;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    int  fail_count;
    int  pending;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    bit  hold_off = 1'b0;

    always #6 i_clk = ~i_clk;

    spot_light_sample dut (.*);

    sls_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_point(i_point), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_sample(o_sample), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Stall the output at random; hold long when asked.
    always @(negedge i_clk) begin
        if (hold_off)
            i_stall <= 1'b1;
        else
            i_stall <= !calm && ($urandom_range(99) < 34);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Hold the item until accepted; insert random gaps before it.
    // Valid stays high on return; drain lowers it, and the next item lowers it only for a random gap.
    task automatic send_point(t_point_in p);
        while (!calm && $urandom_range(99) < 34) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_point <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    function automatic logic [47:0] pack3(logic [15:0] x, logic [15:0] y,
                                          logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic t_point_in rand_point(int spread, logic [47:0] pos);
        t_point_in p;
        if ($urandom_range(3) == 0) begin
            p.point_x = 16'($urandom);
            p.point_y = 16'($urandom);
            p.point_z = 16'($urandom);
        end else begin
            p.point_x = pos[15:0] + 16'($urandom_range(2 * spread) - spread);
            p.point_y = pos[31:16] + 16'($urandom_range(2 * spread) - spread);
            p.point_z = pos[47:32] - 16'($urandom_range(spread));
        end
        return p;
    endfunction

    initial begin
        logic [47:0] pos;
        logic [14:0] fc;
        logic [14:0] ec;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset registers, then extremes and special cases.
        send_point('{16'sd0, 16'sd0, 16'sd0});
        send_point('{16'sd256, 16'sd0, 16'sd0});
        drain();
        pos = pack3(16'h0000, 16'h0000, 16'h0400);
        write_reg(CfgLightPosition, pos);
        write_reg(CfgLightAxis, pack3(16'h0000, 16'h0000, 16'hC000));
        write_reg(CfgLightColour, pack3(16'hFFFF, 16'h8000, 16'h0001));
        write_reg(CfgFullCos, 48'd15000);
        write_reg(CfgEdgeCos, 48'd12000);
        send_point('{16'sd0, 16'sd0, 16'sh0400});
        send_point('{16'sd0, 16'sd0, 16'sd0});
        send_point('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        send_point('{-16'sh8000, -16'sh8000, -16'sh8000});
        send_point('{16'sh7FFF, -16'sh8000, 16'sh7FFF});
        send_point('{16'sd300, 16'sd0, 16'sd0});
        send_point('{16'sd800, 16'sd0, 16'sd0});
        send_point('{16'sd1500, 16'sd0, -16'sd100});
        drain();
        // Edge above full, then black colour with extreme thresholds.
        write_reg(CfgEdgeCos, 48'd16000);
        write_reg(CfgFullCos, 48'd10000);
        send_point('{16'sd300, 16'sd0, 16'sd0});
        send_point('{16'sd900, 16'sd0, 16'sd0});
        drain();
        write_reg(CfgLightColour, 48'd0);
        write_reg(CfgFullCos, 48'h7FFF);
        write_reg(CfgEdgeCos, 48'd0);
        send_point('{16'sd100, 16'sd0, 16'sd0});
        drain();
        write_reg(CfgLightAxis, pack3(16'h7FFF, 16'h8000, 16'h8000));
        write_reg(CfgFullCos, 48'd0);
        send_point('{16'sd100, 16'sd50, -16'sd20});
        send_point('{-16'sd100, 16'sd50, 16'sd20});
        drain();

        // Random phases over several settings.
        for (int ph = 0; ph < 6; ph++) begin
            pos = (ph == 5) ? 48'($urandom) | (48'($urandom) << 32) : pack3(
                16'($urandom_range(2000) - 1000), 16'($urandom_range(2000) - 1000),
                16'($urandom_range(2000) - 1000));
            fc = (ph == 0) ? 15'd16384 : (ph == 1) ? 15'd0 : 15'($urandom_range(16384));
            ec = (ph == 0) ? 15'd0 : (ph == 4) ? 15'h7FFF : 15'($urandom_range(fc));
            write_reg(CfgLightPosition, pos);
            write_reg(CfgLightAxis, (ph == 3) ? 48'($urandom) | (48'($urandom) << 32)
                                              : pack3(16'd0, 16'd0, 16'hC000));
            write_reg(CfgLightColour, (ph == 2) ? 48'hFFFF_FFFF_FFFF
                                                : 48'($urandom) | (48'($urandom) << 16));
            write_reg(CfgFullCos, 48'(fc));
            write_reg(CfgEdgeCos, 48'(ec));
            calm = (ph == 2);
            if (ph == 1) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (200) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 90; n++)
                send_point(rand_point((n % 3 == 0) ? 4000 : 600, pos));
            calm = 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/sls_pkg.sv
rtl/sls_front.sv
rtl/sls_queue.sv
rtl/sls_back.sv
rtl/spot_light_sample.sv
tb/sls_checker.sv
tb/tb_top.sv
